[design/bgms_pkg.sv]
package bgms_pkg;

	localparam int TS_W       = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [2:0] MODE_LAST    = 3'd4;
	localparam logic [2:0] RAINBOW_LAST = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_DC_WINDOW   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAVE_HOLD   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_HOLD  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 8'd3;

	localparam logic [15:0] DC_WINDOW_RST   = 16'd300;
	localparam logic [15:0] SAVE_HOLD_RST   = 16'd1000;
	localparam logic [15:0] CLEAR_HOLD_RST  = 16'd5000;
	localparam logic [7:0]  COLOR_COUNT_RST = 8'd8;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_SAVE  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef struct packed {
		logic [15:0] dc_window;
		logic [15:0] save_hold;
		logic [15:0] clear_hold;
		logic [7:0]  color_count;
	} cfg_t;

	typedef struct packed {
		logic            button_level;
		logic [TS_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic [2:0] display_mode;
		logic [2:0] rainbow_style;
		logic [7:0] color_index;
		logic [1:0] request;
	} result_t;

endpackage

[design/bgms_ifs.sv]
interface bgms_sample_if import bgms_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            button_level;
	logic [TS_W-1:0] now_ms;

	modport source (output valid, output button_level, output now_ms, input ready);
	modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

interface bgms_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] display_mode;
	logic [2:0] rainbow_style;
	logic [7:0] color_index;
	logic [1:0] request;

	modport source (output valid, output display_mode, output rainbow_style,
		output color_index, output request, input ready);
	modport sink   (input valid, input display_mode, input rainbow_style,
		input color_index, input request, output ready);
endinterface

interface bgms_cfg_if import bgms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[design/bgms_cfg_regs.sv]
module bgms_cfg_regs import bgms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bgms_cfg_if.sink  cfg,
	output cfg_t      cfg_o
);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_o     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dc_window   <= DC_WINDOW_RST;
			cfg_q.save_hold   <= SAVE_HOLD_RST;
			cfg_q.clear_hold  <= CLEAR_HOLD_RST;
			cfg_q.color_count <= COLOR_COUNT_RST;
		end else if (cfg.valid) begin
			// writes to unknown indexes are dropped
			case (cfg.index)
				REG_DC_WINDOW:   cfg_q.dc_window   <= cfg.data;
				REG_SAVE_HOLD:   cfg_q.save_hold   <= cfg.data;
				REG_CLEAR_HOLD:  cfg_q.clear_hold  <= cfg.data;
				REG_COLOR_COUNT: cfg_q.color_count <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

endmodule

[design/bgms_gesture.sv]
module bgms_gesture import bgms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  sample_t smp,
	input  cfg_t    cfg,
	output result_t res
);

	logic            last_level_q;
	logic [TS_W-1:0] press_time_q;
	logic            second_click_q;
	logic [2:0]      mode_q;
	logic [2:0]      rainbow_q;
	logic [7:0]      color_q;

	logic            second_click_d;
	logic [TS_W-1:0] press_time_d;
	logic [2:0]      mode_d;
	logic [2:0]      rainbow_d;
	logic [7:0]      color_d;
	req_t            req_d;

	logic [TS_W-1:0] gap;
	logic [2:0]      mode_back;
	logic [2:0]      mode_fwd;
	logic [2:0]      rainbow_fwd;
	logic [8:0]      color_inc;
	logic [7:0]      color_fwd;

	always_comb begin
		gap         = smp.now_ms - press_time_q;
		mode_back   = (mode_q == 3'd0) ? MODE_LAST : mode_q - 3'd1;
		mode_fwd    = (mode_q >= MODE_LAST) ? 3'd0 : mode_q + 3'd1;
		rainbow_fwd = (rainbow_q >= RAINBOW_LAST) ? 3'd0 : rainbow_q + 3'd1;
		color_inc   = {1'b0, color_q} + 9'd1;
		color_fwd   = (color_inc >= {1'b0, cfg.color_count}) ? 8'd0 : color_inc[7:0];

		second_click_d = second_click_q;
		press_time_d   = press_time_q;
		mode_d         = mode_q;
		rainbow_d      = rainbow_q;
		color_d        = color_q;
		req_d          = REQ_NONE;

		if (smp.button_level != last_level_q) begin
			if (smp.button_level) begin
				if (gap <= TS_W'(cfg.dc_window))
					second_click_d = 1'b1;
				press_time_d = smp.now_ms;
			end else if (gap >= TS_W'(cfg.clear_hold)) begin
				req_d = REQ_CLEAR;
			end else if (gap >= TS_W'(cfg.save_hold)) begin
				second_click_d = 1'b0;
				req_d          = REQ_SAVE;
			end else if (second_click_q) begin
				// step back first, then the style choice follows the restored mode
				mode_d = mode_back;
				if (mode_back == 3'd0 || mode_back == 3'd1)
					rainbow_d = rainbow_fwd;
				else
					color_d = color_fwd;
				second_click_d = 1'b0;
			end else begin
				mode_d = mode_fwd;
			end
		end

		res.display_mode  = mode_d;
		res.rainbow_style = rainbow_d;
		res.color_index   = color_d;
		res.request       = req_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q   <= 1'b0;
			press_time_q   <= '0;
			second_click_q <= 1'b0;
			mode_q         <= 3'd0;
			rainbow_q      <= 3'd0;
			color_q        <= 8'd0;
		end else if (step) begin
			last_level_q   <= smp.button_level;
			press_time_q   <= press_time_d;
			second_click_q <= second_click_d;
			mode_q         <= mode_d;
			rainbow_q      <= rainbow_d;
			color_q        <= color_d;
		end
	end

endmodule

[design/button_gesture_mode_selector_core.sv]
// Button gesture decoder: each transfer on samp carries one button level sample with its
// millisecond timestamp and yields exactly one transfer on res with the current mode,
// rainbow style, color index and a save or clear request for that sample. A sample is
// registered on entry, decoded combinationally against the gesture state and captured in
// the output register when that register is free or being drained, and one sample per
// cycle is sustained while res.ready stays high. Configuration writes on cfg are always
// accepted and take effect on the next sample.
module button_gesture_mode_selector_core import bgms_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bgms_sample_if.sink  samp,
	bgms_result_if.source res,
	bgms_cfg_if.sink     cfg
);

	cfg_t    cfg_cur;
	logic    smp_vld_s1;
	sample_t smp_s1;
	logic    out_vld_s2;
	result_t out_s2;
	result_t res_d;
	logic    advance;

	bgms_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_cur)
	);

	bgms_gesture u_gesture (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.smp    (smp_s1),
		.cfg    (cfg_cur),
		.res    (res_d)
	);

	// move the held sample on when the output register is free or being drained
	assign advance    = smp_vld_s1 && (!out_vld_s2 || res.ready);
	assign samp.ready = !smp_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_vld_s1 <= 1'b0;
			out_vld_s2 <= 1'b0;
		end else begin
			if (samp.ready)
				smp_vld_s1 <= samp.valid;
			if (advance)
				out_vld_s2 <= 1'b1;
			else if (res.ready)
				out_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (samp.ready && samp.valid) begin
			smp_s1.button_level <= samp.button_level;
			smp_s1.now_ms       <= samp.now_ms;
		end
		if (advance)
			out_s2 <= res_d;
	end

	assign res.valid         = out_vld_s2;
	assign res.display_mode  = out_s2.display_mode;
	assign res.rainbow_style = out_s2.rainbow_style;
	assign res.color_index   = out_s2.color_index;
	assign res.request       = out_s2.request;

endmodule
